>>> hw/rtl/assert_macros.svh
// assertion macros included by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/sklf_pkg.sv
// types and constants of the sort key field locator
package sklf_pkg;

   localparam int PosW  = 7;
   localparam int CharW = 8;

   // key modes
   localparam logic [1:0] ModeColumn = 2'd0;
   localparam logic [1:0] ModeBlank  = 2'd1;
   localparam logic [1:0] ModeDelim  = 2'd2;

   // csr register indexes
   localparam logic [1:0] CsrKeyMode   = 2'd0;
   localparam logic [1:0] CsrDelimiter = 2'd1;
   localparam logic [1:0] CsrKeyIndex  = 2'd2;

   localparam logic [CharW-1:0] SpaceChar    = 8'd32;
   localparam logic [CharW-1:0] DelimReset   = 8'd44;

   typedef struct packed {
      logic [1:0]       key_mode;
      logic [CharW-1:0] delimiter_char;
      logic [PosW-1:0]  key_index;
   } sklf_cfg_type;

   typedef struct packed {
      logic [PosW-1:0] key_offset;
      logic [PosW-1:0] line_length;
      logic            too_long;
   } sklf_result_type;

endpackage

>>> hw/rtl/sklf_line_tracker.sv
// per-line state and key search, one word per cycle while char_accept is high
module sklf_line_tracker import sklf_pkg::*; #(
   parameter int MAX_LINE = 127
) (
   input  logic              clock,
   input  logic              reset,
   input  sklf_cfg_type      cfg,
   input  logic              char_accept,
   input  logic [CharW-1:0]  char_code,
   input  logic              line_end,
   output sklf_result_type   result
);

   localparam logic [PosW-1:0] MaxLineC = PosW'(MAX_LINE);

   logic [PosW-1:0]  char_position_ff, char_position_in;
   logic [PosW-1:0]  fields_to_skip_ff, fields_to_skip_in;
   logic             key_found_ff, key_found_in;
   logic [PosW-1:0]  found_offset_ff, found_offset_in;
   logic [CharW-1:0] previous_char_ff, previous_char_in;
   logic             previous_was_skipping_ff, previous_was_skipping_in;
   logic             overflow_seen_ff, overflow_seen_in;

   logic            in_range;
   logic            field_mode;
   logic [PosW-1:0] skip_base;
   logic            word_end;
   logic [PosW-1:0] skip_after_word;
   logic            skipping;
   logic            found_now;
   logic [PosW-1:0] line_len;

   always_comb begin
      in_range   = char_position_ff < MaxLineC;
      field_mode = (cfg.key_mode == ModeBlank) || (cfg.key_mode == ModeDelim);
      skip_base  = (char_position_ff == '0) ? cfg.key_index : fields_to_skip_ff;
      word_end   = (cfg.key_mode == ModeBlank) && previous_was_skipping_ff &&
                   (previous_char_ff > SpaceChar) && (char_code <= SpaceChar);
      skip_after_word = (word_end && (skip_base != '0)) ? skip_base - 1'b1 : skip_base;
      skipping   = skip_after_word != '0;
      found_now  = !skipping && !key_found_ff &&
                   ((cfg.key_mode == ModeDelim) || (char_code > SpaceChar));

      char_position_in         = char_position_ff;
      fields_to_skip_in        = fields_to_skip_ff;
      key_found_in             = key_found_ff;
      found_offset_in          = found_offset_ff;
      previous_char_in         = previous_char_ff;
      previous_was_skipping_in = previous_was_skipping_ff;
      overflow_seen_in         = overflow_seen_ff;

      if (!in_range) begin
         overflow_seen_in = 1'b1;
      end else begin
         fields_to_skip_in = skip_base;
         if (field_mode) begin
            fields_to_skip_in = skip_after_word;
            if (skipping && (cfg.key_mode == ModeDelim) && (char_code == cfg.delimiter_char)) begin
               fields_to_skip_in = skip_after_word - 1'b1;
            end
            if (found_now) begin
               key_found_in    = 1'b1;
               found_offset_in = char_position_ff;
            end
            previous_was_skipping_in = skipping;
            previous_char_in         = char_code;
         end
         char_position_in = char_position_ff + 1'b1;
      end

      line_len           = char_position_in;
      result.line_length = line_len;
      result.too_long    = overflow_seen_in;
      if (field_mode) begin
         result.key_offset = key_found_in ? found_offset_in : line_len;
      end else begin
         result.key_offset = (cfg.key_index < line_len) ? cfg.key_index : line_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (char_accept && line_end)) begin
         char_position_ff         <= '0;
         fields_to_skip_ff        <= '0;
         key_found_ff             <= 1'b0;
         found_offset_ff          <= '0;
         previous_char_ff         <= '0;
         previous_was_skipping_ff <= 1'b0;
         overflow_seen_ff         <= 1'b0;
      end else if (char_accept) begin
         char_position_ff         <= char_position_in;
         fields_to_skip_ff        <= fields_to_skip_in;
         key_found_ff             <= key_found_in;
         found_offset_ff          <= found_offset_in;
         previous_char_ff         <= previous_char_in;
         previous_was_skipping_ff <= previous_was_skipping_in;
         overflow_seen_ff         <= overflow_seen_in;
      end
   end

endmodule

>>> hw/rtl/sort_key_field_locator_top.sv
// a line's result word is registered once its last character is accepted
// one character word per cycle while req_stall is low, set by the line tracker update
// a result register plus one skid entry keep input flowing while the output is stalled;
// req_stall rises only when the skid entry is occupied
// reset (synchronous, active high) clears the line state, the output stages and
// restores key_mode 0, delimiter 44, key_index 0
`include "assert_macros.svh"

module sort_key_field_locator_top import sklf_pkg::*; #(
   parameter int MAX_LINE = 127
) (
   input  logic             clock,
   input  logic             reset,
   // configuration writes
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [CharW-1:0] csr_write_data,
   // character words
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CharW-1:0] req_char_code,
   input  logic             req_line_end,
   // result words
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PosW-1:0]  rsp_key_offset,
   output logic [PosW-1:0]  rsp_line_length,
   output logic             rsp_too_long
);

   localparam logic [PosW-1:0] MaxLineC = PosW'(MAX_LINE);

   // configuration registers
   sklf_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_mode       <= ModeColumn;
         cfg_ff.delimiter_char <= DelimReset;
         cfg_ff.key_index      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrKeyMode:   cfg_ff.key_mode       <= csr_write_data[1:0];
            CsrDelimiter: cfg_ff.delimiter_char <= csr_write_data;
            CsrKeyIndex:  cfg_ff.key_index      <= csr_write_data[PosW-1:0];
            default:      ;  // unused index, write dropped
         endcase
      end
   end

   // input handshake
   logic req_accept;
   logic skid_valid_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   // per-character work
   sklf_result_type line_result;

   sklf_line_tracker #(
      .MAX_LINE (MAX_LINE)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .char_accept (req_accept),
      .char_code   (req_char_code),
      .line_end    (req_line_end),
      .result      (line_result)
   );

   // result register and skid entry
   logic            new_result;
   logic            rsp_pop;
   logic            out_valid_ff;
   sklf_result_type out_data_ff;
   sklf_result_type skid_data_ff;

   assign new_result = req_accept && req_line_end;
   assign rsp_pop    = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no accepts while the skid entry is full
         if (rsp_pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (new_result) begin
         if (out_valid_ff && !rsp_pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (new_result) begin
         if (out_valid_ff && !rsp_pop) begin
            skid_data_ff <= line_result;
         end else begin
            out_data_ff <= line_result;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_key_offset  = out_data_ff.key_offset;
   assign rsp_line_length = out_data_ff.line_length;
   assign rsp_too_long    = out_data_ff.too_long;

   // checks
   `ASSERT_IMPLIES(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff)
   `ASSERT_IMPLIES(a_offset_in_line, clock, reset, out_valid_ff,
                   (out_data_ff.key_offset <= out_data_ff.line_length) &&
                   (out_data_ff.line_length != '0))
   `ASSERT_IMPLIES(a_long_saturates, clock, reset, out_valid_ff && out_data_ff.too_long,
                   out_data_ff.line_length == MaxLineC)

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the sort key field locator: directed lines, then random lines
`timescale 1ns / 1ps

module tb_top;
   import sklf_pkg::*;

   localparam int MaxLine = 127;
   // key_mode 3 has no name in the package and falls back to column mode
   localparam logic [1:0] ModeThree = 2'd3;
   localparam int PhaseCount = 12;
   localparam int PhaseWords = 60;
   localparam sklf_result_type NoResult = '0;

   // one row of the directed table: an optional register load before the word,
   // the word itself, and a result typed in by hand where it is obvious
   typedef struct packed {
      logic            load;
      logic [1:0]      mode;
      logic [CharW-1:0] delim;
      logic [PosW-1:0] kidx;
      logic [CharW-1:0] ch;
      logic            last;
      logic            typed;
      sklf_result_type typed_result;
   } line_row_type;

   localparam int RowCount = 18;
   localparam line_row_type LineRows [RowCount] = '{
      // registers straight out of reset: column 0
      '{1'b0, ModeColumn, 8'd44, 7'd0,   "A",    1'b1, 1'b1, '{7'd0, 7'd1, 1'b0}},
      // column past the line end is clipped to the length
      '{1'b1, ModeColumn, 8'd44, 7'd126, "x",    1'b0, 1'b0, NoResult},
      '{1'b0, ModeColumn, 8'd44, 7'd126, "y",    1'b1, 1'b1, '{7'd2, 7'd2, 1'b0}},
      // mode three acts as column mode
      '{1'b1, ModeThree,  8'd44, 7'd1,   "a",    1'b0, 1'b0, NoResult},
      '{1'b0, ModeThree,  8'd44, 7'd1,   "b",    1'b1, 1'b1, '{7'd1, 7'd2, 1'b0}},
      // skip one blank-separated word
      '{1'b1, ModeBlank,  8'd44, 7'd1,   "a",    1'b0, 1'b0, NoResult},
      '{1'b0, ModeBlank,  8'd44, 7'd1,   " ",    1'b0, 1'b0, NoResult},
      '{1'b0, ModeBlank,  8'd44, 7'd1,   "b",    1'b1, 1'b0, NoResult},
      // a word that ends the line skips nothing, so no key
      '{1'b1, ModeBlank,  8'd44, 7'd1,   "a",    1'b0, 1'b0, NoResult},
      '{1'b0, ModeBlank,  8'd44, 7'd1,   "b",    1'b1, 1'b1, '{7'd2, 7'd2, 1'b0}},
      // space used literally as the delimiter
      '{1'b1, ModeDelim,  8'd32, 7'd1,   "a",    1'b0, 1'b0, NoResult},
      '{1'b0, ModeDelim,  8'd32, 7'd1,   " ",    1'b0, 1'b0, NoResult},
      '{1'b0, ModeDelim,  8'd32, 7'd1,   "b",    1'b1, 1'b0, NoResult},
      // zero byte as plain text, top byte as the delimiter
      '{1'b1, ModeDelim,  8'hFF, 7'd1,   8'h00,  1'b0, 1'b0, NoResult},
      '{1'b0, ModeDelim,  8'hFF, 7'd1,   8'hFF,  1'b1, 1'b0, NoResult},
      // control byte counts as blank
      '{1'b1, ModeBlank,  8'd44, 7'd0,   8'h01,  1'b0, 1'b0, NoResult},
      '{1'b0, ModeBlank,  8'd44, 7'd0,   8'hFF,  1'b1, 1'b0, NoResult},
      // nothing to skip: even the delimiter itself is the key
      '{1'b1, ModeDelim,  8'h01, 7'd0,   8'h01,  1'b1, 1'b0, NoResult}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [1:0]       csr_index = CsrKeyMode;
   logic [CharW-1:0] csr_write_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [CharW-1:0] req_char_code = '0;
   logic             req_line_end = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [PosW-1:0]  rsp_key_offset;
   logic [PosW-1:0]  rsp_line_length;
   logic             rsp_too_long;

   // a one-in-idle_odds draw starts an idle burst on each side, 0 turns idling off
   int idle_odds = 0;
   int stall_left = 0;
   int mismatches = 0;

   // predictor copy of the registers
   logic [1:0]       cfg_mode;
   logic [CharW-1:0] cfg_delim;
   logic [PosW-1:0]  cfg_kidx;

   // predictor copy of the line tracker
   logic [PosW-1:0]  ln_pos;
   logic [7:0]       ln_skip;
   logic             ln_found;
   logic [PosW-1:0]  ln_found_at;
   logic [CharW-1:0] ln_prev;
   logic             ln_prev_skipping;
   logic             ln_over;

   // line results still owed by the block, oldest first
   sklf_result_type line_results_due [$];

   sort_key_field_locator_top #(.MAX_LINE(MaxLine)) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_offset  (rsp_key_offset),
      .rsp_line_length (rsp_line_length),
      .rsp_too_long    (rsp_too_long)
   );

   always #5 clock = ~clock;

   function automatic void clear_line();
      ln_pos = '0;
      ln_skip = '0;
      ln_found = 1'b0;
      ln_found_at = '0;
      ln_prev = '0;
      ln_prev_skipping = 1'b0;
      ln_over = 1'b0;
   endfunction

   // advance the line tracker by one character; returns 1 when the line closes
   function automatic bit locate_key(input logic [CharW-1:0] ch, input logic last,
                                     output sklf_result_type res);
      logic            field_mode;
      logic            skipping;
      logic [PosW-1:0] len;
      field_mode = (cfg_mode == ModeBlank) || (cfg_mode == ModeDelim);
      res = NoResult;
      if (int'(ln_pos) >= MaxLine) begin
         // characters past the limit are dropped from the search
         ln_over = 1'b1;
      end else begin
         if (ln_pos == 0) ln_skip = {1'b0, cfg_kidx};
         if (field_mode) begin
            // a word ends when a nonblank is followed by a blank
            if (cfg_mode == ModeBlank && ln_prev_skipping && ln_prev > SpaceChar &&
                ch <= SpaceChar && ln_skip != 0)
               ln_skip--;
            skipping = (ln_skip != 0);
            if (skipping) begin
               if (cfg_mode == ModeDelim && ch == cfg_delim) ln_skip--;
            end else if (!ln_found && (cfg_mode == ModeDelim || ch > SpaceChar)) begin
               ln_found = 1'b1;
               ln_found_at = ln_pos;
            end
            ln_prev_skipping = skipping;
            ln_prev = ch;
         end
         ln_pos++;
      end
      if (!last) return 1'b0;
      len = ln_pos;
      if (field_mode)
         res.key_offset = ln_found ? ln_found_at : len;
      else
         res.key_offset = (cfg_kidx < len) ? cfg_kidx : len;
      res.line_length = len;
      res.too_long = ln_over;
      clear_line();
      return 1'b1;
   endfunction

   // text with some structure: blanks, delimiters and plain bytes mixed
   function automatic logic [CharW-1:0] pick_char(input logic [1:0] mode,
                                                  input logic [CharW-1:0] delim);
      int r;
      r = $urandom_range(0, 9);
      if (mode == ModeDelim && r < 3) return delim;
      if (r < 6) return CharW'($urandom_range(0, 32));
      if (r < 9) return CharW'($urandom_range(33, 255));
      return CharW'($urandom_range(0, 255));
   endfunction

   // hand over one character word, with an optional idle burst before it
   task automatic send_word(input logic [CharW-1:0] ch, input logic last,
                            input logic typed, input sklf_result_type typed_result);
      sklf_result_type res;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= ch;
      req_line_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge; valid stays up in case the next word follows at once
      if (locate_key(ch, last, res))
         line_results_due.push_back(typed ? typed_result : res);
   endtask

   // let every owed result come out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (line_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // load all three registers back to back; enable stays high across them
   task automatic set_config(input logic [1:0] mode, input logic [CharW-1:0] delim,
                             input logic [PosW-1:0] kidx);
      csr_write_enable <= 1'b1;
      csr_index <= CsrKeyMode;
      csr_write_data <= CharW'(mode);
      @(posedge clock);
      csr_index <= CsrDelimiter;
      csr_write_data <= delim;
      @(posedge clock);
      csr_index <= CsrKeyIndex;
      csr_write_data <= CharW'(kidx);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_mode = mode;
      cfg_delim = delim;
      cfg_kidx = kidx;
   endtask

   // receiver side: random stall bursts while idling is on
   always @(posedge clock) begin
      if (reset || idle_odds == 0) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && $urandom_range(1, idle_odds) == 1)
            stall_left = $urandom_range(1, 8);
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker: every accepted result word against the oldest owed one
   always @(posedge clock) begin : rsp_check
      sklf_result_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_results_due.size() == 0) begin
            $display("%0t: result word with none owed: offset %0d length %0d too_long %0b",
                     $time, rsp_key_offset, rsp_line_length, rsp_too_long);
            mismatches++;
         end else begin
            owed = line_results_due.pop_front();
            if (rsp_key_offset !== owed.key_offset) begin
               $display("%0t: key_offset expected %0d actual %0d",
                        $time, owed.key_offset, rsp_key_offset);
               mismatches++;
            end
            if (rsp_line_length !== owed.line_length) begin
               $display("%0t: line_length expected %0d actual %0d",
                        $time, owed.line_length, rsp_line_length);
               mismatches++;
            end
            if (rsp_too_long !== owed.too_long) begin
               $display("%0t: too_long expected %0b actual %0b",
                        $time, owed.too_long, rsp_too_long);
               mismatches++;
            end
         end
      end
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [1:0]       mode;
      logic [CharW-1:0] delim;
      logic [PosW-1:0]  kidx;
      int               sent;
      int               len;
      cfg_mode = ModeColumn;
      cfg_delim = DelimReset;
      cfg_kidx = '0;
      clear_line();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed lines, a register load wherever a row asks for one
      idle_odds = 3;
      for (int i = 0; i < RowCount; i++) begin
         if (LineRows[i].load) begin
            drain();
            set_config(LineRows[i].mode, LineRows[i].delim, LineRows[i].kidx);
         end
         send_word(LineRows[i].ch, LineRows[i].last, LineRows[i].typed,
                   LineRows[i].typed_result);
      end

      // random phases, each under one register setting
      for (int phase = 0; phase < PhaseCount; phase++) begin
         if (phase < 4) begin
            // extreme settings first, one per mode
            mode = phase[1:0];
            delim = phase[1] ? 8'hFF : 8'h00;
            kidx = phase[0] ? 7'd0 : 7'd127;
         end else begin
            mode = 2'($urandom_range(0, 3));
            delim = ($urandom_range(0, 3) == 0) ? SpaceChar : CharW'($urandom_range(0, 255));
            if (mode == ModeBlank || mode == ModeDelim)
               kidx = ($urandom_range(0, 7) == 0) ? PosW'($urandom_range(0, 127))
                                                  : PosW'($urandom_range(0, 4));
            else
               kidx = ($urandom_range(0, 3) == 0) ? PosW'($urandom_range(0, 127))
                                                  : PosW'($urandom_range(0, 24));
         end
         drain();
         // no idling at all near the end, otherwise a random mix
         if (phase >= PhaseCount - 2) begin
            idle_odds = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 2;
               default: idle_odds = 6;
            endcase
         end
         set_config(mode, delim, kidx);
         sent = 0;
         while (sent < PhaseWords) begin
            // mostly short lines, now and then one around or past the limit
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 140)
                                               : $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
               send_word(pick_char(mode, delim), k == len - 1, 1'b0, NoResult);
            sent += len;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
